FILE: hw/rtl/apd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apd_pkg: shared types and constants of the AArch64 instruction predecoder
// Holds the instruction class codes, the mask and match constants and the
// packed item and result records passed between the decoder and the top level.
// ----------------------------------------------------------------------------
package apd_pkg;

  typedef enum logic [3:0] {
    CLS_NONE = 4'd0,
    CLS_ADRP = 4'd1,
    CLS_ADD  = 4'd2,
    CLS_LDR  = 4'd3,
    CLS_BL   = 4'd4,
    CLS_B    = 4'd5,
    CLS_BLR  = 4'd6,
    CLS_BR   = 4'd7,
    CLS_RET  = 4'd8,
    CLS_MOV  = 4'd9,
    CLS_MOVZ = 4'd10
  } apd_class_t;

  localparam logic [31:0] ADRP_MASK   = 32'h9F00_0000;
  localparam logic [31:0] ADRP_MATCH  = 32'h9000_0000;
  localparam logic [31:0] ADD_MASK    = 32'h7F80_0000;
  localparam logic [31:0] ADD_MATCH   = 32'h1100_0000;
  localparam logic [31:0] LDR_MASK    = 32'hFFC0_0000;
  localparam logic [31:0] LDR32_MATCH = 32'hB940_0000;
  localparam logic [31:0] LDR64_MATCH = 32'hF940_0000;
  localparam logic [31:0] BR_IMM_MASK = 32'hFC00_0000;
  localparam logic [31:0] BL_MATCH    = 32'h9400_0000;
  localparam logic [31:0] B_MATCH     = 32'h1400_0000;
  localparam logic [31:0] BR_REG_MASK = 32'hFFFF_FC1F;
  localparam logic [31:0] BLR_MATCH   = 32'hD63F_0000;
  localparam logic [31:0] BR_MATCH    = 32'hD61F_0000;
  localparam logic [31:0] RET_MATCH   = 32'hD65F_0000;
  localparam logic [31:0] MOV_MASK    = 32'h7FE0_FFE0;
  localparam logic [31:0] MOV_MATCH   = 32'h2A00_03E0;
  localparam logic [31:0] MOVZ_MASK   = 32'h7F80_0000;
  localparam logic [31:0] MOVZ_MATCH  = 32'h5280_0000;

  localparam logic [3:0] SCALE_WORD  = 4'd4;
  localparam logic [3:0] SCALE_DWORD = 4'd8;

  typedef struct packed {
    apd_class_t         insn_class;
    logic [4:0]         dest_reg;
    logic [4:0]         base_reg;
    logic [4:0]         source_reg;
    logic [23:0]        immediate;
    logic [3:0]         access_scale;
    logic [63:0]        page_target;
    logic signed [27:0] branch_offset;
  } apd_result_t;

  typedef struct packed {
    logic [63:0] pc;
    logic [31:0] instruction_word;
  } apd_item_t;

endpackage : apd_pkg
`default_nettype wire

FILE: hw/rtl/apd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apd_in_if: input channel of the predecoder
// Valid/ready channel carrying a program counter and one instruction word.
// ----------------------------------------------------------------------------
interface apd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] pc;
  logic [31:0] instruction_word;

  modport source (output valid, output pc, output instruction_word, input ready);
  modport sink   (input valid, input pc, input instruction_word, output ready);
endinterface : apd_in_if
`default_nettype wire

FILE: hw/rtl/apd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apd_out_if: result channel of the predecoder
// Valid/ready channel carrying the class and fields of one decoded word.
// ----------------------------------------------------------------------------
interface apd_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         insn_class;
  logic [4:0]         dest_reg;
  logic [4:0]         base_reg;
  logic [4:0]         source_reg;
  logic [23:0]        immediate;
  logic [3:0]         access_scale;
  logic [63:0]        page_target;
  logic signed [27:0] branch_offset;

  modport source (output valid, output insn_class, output dest_reg, output base_reg,
                  output source_reg, output immediate, output access_scale,
                  output page_target, output branch_offset, input ready);
  modport sink   (input valid, input insn_class, input dest_reg, input base_reg,
                  input source_reg, input immediate, input access_scale,
                  input page_target, input branch_offset, output ready);
endinterface : apd_out_if
`default_nettype wire

FILE: hw/rtl/apd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apd_decode: combinational classifier and field extractor
// Sorts one instruction word by mask and match and pulls out its fields.
// ----------------------------------------------------------------------------
module apd_decode (
  input  wire apd_pkg::apd_item_t   item,
  output apd_pkg::apd_result_t      result
);

  logic [31:0] w;
  logic [20:0] adrp_imm;
  logic [63:0] adrp_off;
  logic [63:0] pc_page;

  assign w        = item.instruction_word;
  assign adrp_imm = {w[23:5], w[30:29]};
  assign adrp_off = {{31{adrp_imm[20]}}, adrp_imm, 12'h000};
  assign pc_page  = {item.pc[63:12], 12'h000};

  always_comb begin
    result = '0;
    result.insn_class = apd_pkg::CLS_NONE;
    if ((w & apd_pkg::ADRP_MASK) == apd_pkg::ADRP_MATCH) begin
      result.insn_class  = apd_pkg::CLS_ADRP;
      result.dest_reg    = w[4:0];
      result.page_target = pc_page + adrp_off;
    end else if ((w & apd_pkg::ADD_MASK) == apd_pkg::ADD_MATCH) begin
      result.insn_class = apd_pkg::CLS_ADD;
      result.dest_reg   = w[4:0];
      result.base_reg   = w[9:5];
      // Bit 22 selects the shifted form of the 12-bit immediate.
      result.immediate  = w[22] ? {w[21:10], 12'h000} : {12'h000, w[21:10]};
    end else if (((w & apd_pkg::LDR_MASK) == apd_pkg::LDR32_MATCH) ||
                 ((w & apd_pkg::LDR_MASK) == apd_pkg::LDR64_MATCH)) begin
      result.insn_class   = apd_pkg::CLS_LDR;
      result.dest_reg     = w[4:0];
      result.base_reg     = w[9:5];
      result.immediate    = {12'h000, w[21:10]};
      result.access_scale = w[30] ? apd_pkg::SCALE_DWORD : apd_pkg::SCALE_WORD;
    end else if ((w & apd_pkg::BR_IMM_MASK) == apd_pkg::BL_MATCH) begin
      result.insn_class    = apd_pkg::CLS_BL;
      result.branch_offset = {w[25:0], 2'b00};
    end else if ((w & apd_pkg::BR_IMM_MASK) == apd_pkg::B_MATCH) begin
      result.insn_class    = apd_pkg::CLS_B;
      result.branch_offset = {w[25:0], 2'b00};
    end else if ((w & apd_pkg::BR_REG_MASK) == apd_pkg::BLR_MATCH) begin
      result.insn_class = apd_pkg::CLS_BLR;
      result.base_reg   = w[9:5];
    end else if ((w & apd_pkg::BR_REG_MASK) == apd_pkg::BR_MATCH) begin
      result.insn_class = apd_pkg::CLS_BR;
      result.base_reg   = w[9:5];
    end else if ((w & apd_pkg::BR_REG_MASK) == apd_pkg::RET_MATCH) begin
      result.insn_class = apd_pkg::CLS_RET;
      result.base_reg   = w[9:5];
    end else if ((w & apd_pkg::MOV_MASK) == apd_pkg::MOV_MATCH) begin
      result.insn_class = apd_pkg::CLS_MOV;
      result.dest_reg   = w[4:0];
      result.source_reg = w[20:16];
    end else if ((w & apd_pkg::MOVZ_MASK) == apd_pkg::MOVZ_MATCH) begin
      result.insn_class = apd_pkg::CLS_MOVZ;
    end
  end

endmodule : apd_decode
`default_nettype wire

FILE: hw/rtl/aarch64_instruction_predecoder.sv
`default_nettype none
// An accepted beat passes the input register, the decoder, then the result register.
// Throughput: one beat per cycle while out_ch.ready is high (two-register pipeline).
// Reset: rst_n is synchronous and active low; it empties both pipeline registers.
// There is no other state, so no warm-up or clearing pass follows reset.
// ----------------------------------------------------------------------------
// aarch64_instruction_predecoder: top level of the AArch64 predecoder
// Registers each incoming beat, decodes it in one combinational pass and
// holds the result in an output register until the consumer takes it.
// ----------------------------------------------------------------------------
module aarch64_instruction_predecoder (
  input  wire          clk,
  input  wire          rst_n,
  apd_in_if.sink       in_ch,
  apd_out_if.source    out_ch
);

  // Input register: captures pc and instruction word of an accepted beat.
  logic                  in_valid_r;
  logic                  in_valid_nxt;
  apd_pkg::apd_item_t    in_data_r;

  // Result register: holds the decoded beat until the consumer takes it.
  logic                  res_valid_r;
  logic                  res_valid_nxt;
  apd_pkg::apd_result_t  res_data_r;

  apd_pkg::apd_result_t  dec_result;
  logic                  res_load;
  logic                  in_load;

  // The result register can load when it is empty or its beat leaves now.
  // The input register can load when it is empty or its beat moves on now.
  // Both registers advance together, so a full pipeline keeps one beat per
  // cycle flowing as long as the consumer keeps ready high.
  assign res_load = !res_valid_r || out_ch.ready;
  assign in_load  = !in_valid_r || res_load;

  assign in_ch.ready = in_load;

  assign in_valid_nxt  = in_load ? in_ch.valid : in_valid_r;
  assign res_valid_nxt = res_load ? in_valid_r : res_valid_r;

  apd_decode u_decode (
    .item   (in_data_r),
    .result (dec_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload registers carry no reset; their valid bits qualify them.
  always_ff @(posedge clk) begin
    if (in_load && in_ch.valid) begin
      in_data_r.pc               <= in_ch.pc;
      in_data_r.instruction_word <= in_ch.instruction_word;
    end
    if (res_load && in_valid_r) begin
      res_data_r <= dec_result;
    end
  end

  assign out_ch.valid         = res_valid_r;
  assign out_ch.insn_class    = res_data_r.insn_class;
  assign out_ch.dest_reg      = res_data_r.dest_reg;
  assign out_ch.base_reg      = res_data_r.base_reg;
  assign out_ch.source_reg    = res_data_r.source_reg;
  assign out_ch.immediate     = res_data_r.immediate;
  assign out_ch.access_scale  = res_data_r.access_scale;
  assign out_ch.page_target   = res_data_r.page_target;
  assign out_ch.branch_offset = res_data_r.branch_offset;

`ifndef SYNTHESIS
  // A full pipeline facing a stalled consumer must refuse new beats.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && res_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while pipeline full and stalled");

  // An accepted beat occupies the input register on the next cycle.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> in_valid_r)
    else $error("accepted beat lost from input register");

  // A beat in the input register is never dropped while the result waits.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !res_load) |=> in_valid_r)
    else $error("input register emptied while blocked");

  // Only loads carry an access size, and it is four or eight bytes.
  a_scale: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> ((res_data_r.insn_class == apd_pkg::CLS_LDR) ?
      (res_data_r.access_scale == apd_pkg::SCALE_WORD ||
       res_data_r.access_scale == apd_pkg::SCALE_DWORD) :
      (res_data_r.access_scale == 4'd0)))
    else $error("access scale inconsistent with class");

  // Only immediate branches carry a branch offset.
  a_boff: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_data_r.insn_class != apd_pkg::CLS_B &&
     res_data_r.insn_class != apd_pkg::CLS_BL) |-> (res_data_r.branch_offset == 28'sd0))
    else $error("branch offset set for non-branch class");
`endif

endmodule : aarch64_instruction_predecoder
`default_nettype wire

FILE: tb/aarch64_instruction_predecoder_tb.sv
// ----------------------------------------------------------------------------
// aarch64_instruction_predecoder_tb: self-checking bench for the predecoder
// Drives program counters and instruction words into the input channel.
// Every beat the block takes is decoded by a local model, and the results
// are compared field by field, in order, with the beats on the result
// channel. Both channels idle at random, with one calm stretch.
// ----------------------------------------------------------------------------
module aarch64_instruction_predecoder_tb;

  // Directed words plus random words make up the whole stimulus.
  localparam int unsigned RANDOM_WORDS = 1925;
  // The run stops here even if the block hangs. This limit lies far above
  // the length of a correct run.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Neither side idles while the cycle count is inside this window.
  localparam int unsigned CALM_FROM    = 2000;
  localparam int unsigned CALM_TO      = 3200;
  // A result passes the input and result registers after its beat is taken,
  // so a short drain covers the tail.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PRINT_CAP    = 100;

  logic clk = 1'b0;
  logic rst_n;

  apd_in_if  in_ch ();
  apd_out_if out_ch ();

  aarch64_instruction_predecoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // Beats still to be sent, and the decodes that the block owes us.
  apd_pkg::apd_item_t   pending_words[$];
  apd_pkg::apd_result_t expected_decodes[$];

  int unsigned words_queued;
  int unsigned words_accepted;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  apd_pkg::apd_item_t   next_word;

  // Local decode of one word. Every field a class does not define stays zero.
  function automatic apd_pkg::apd_result_t decode_word(logic [63:0] pc, logic [31:0] w);
    apd_pkg::apd_result_t d;
    logic [63:0] pages;
    d = '0;
    if ((w & apd_pkg::ADRP_MASK) == apd_pkg::ADRP_MATCH) begin
      // The page count is immhi:immlo, sign-extended from 21 bits.
      pages          = {{43{w[23]}}, w[23:5], w[30:29]};
      d.insn_class   = apd_pkg::CLS_ADRP;
      d.dest_reg     = w[4:0];
      d.page_target  = {pc[63:12], 12'h000} + (pages << 12);
    end else if ((w & apd_pkg::ADD_MASK) == apd_pkg::ADD_MATCH) begin
      d.insn_class   = apd_pkg::CLS_ADD;
      d.dest_reg     = w[4:0];
      d.base_reg     = w[9:5];
      d.immediate    = w[22] ? {w[21:10], 12'h000} : {12'h000, w[21:10]};
    end else if ((w & apd_pkg::LDR_MASK) == apd_pkg::LDR32_MATCH ||
                 (w & apd_pkg::LDR_MASK) == apd_pkg::LDR64_MATCH) begin
      d.insn_class   = apd_pkg::CLS_LDR;
      d.dest_reg     = w[4:0];
      d.base_reg     = w[9:5];
      d.immediate    = {12'h000, w[21:10]};
      d.access_scale = w[30] ? apd_pkg::SCALE_DWORD : apd_pkg::SCALE_WORD;
    end else if ((w & apd_pkg::BR_IMM_MASK) == apd_pkg::BL_MATCH ||
                 (w & apd_pkg::BR_IMM_MASK) == apd_pkg::B_MATCH) begin
      d.insn_class    = ((w & apd_pkg::BR_IMM_MASK) == apd_pkg::BL_MATCH) ?
                        apd_pkg::CLS_BL : apd_pkg::CLS_B;
      d.branch_offset = {w[25:0], 2'b00};
    end else if ((w & apd_pkg::BR_REG_MASK) == apd_pkg::BLR_MATCH) begin
      d.insn_class   = apd_pkg::CLS_BLR;
      d.base_reg     = w[9:5];
    end else if ((w & apd_pkg::BR_REG_MASK) == apd_pkg::BR_MATCH) begin
      d.insn_class   = apd_pkg::CLS_BR;
      d.base_reg     = w[9:5];
    end else if ((w & apd_pkg::BR_REG_MASK) == apd_pkg::RET_MATCH) begin
      d.insn_class   = apd_pkg::CLS_RET;
      d.base_reg     = w[9:5];
    end else if ((w & apd_pkg::MOV_MASK) == apd_pkg::MOV_MATCH) begin
      d.insn_class   = apd_pkg::CLS_MOV;
      d.dest_reg     = w[4:0];
      d.source_reg   = w[20:16];
    end else if ((w & apd_pkg::MOVZ_MASK) == apd_pkg::MOVZ_MATCH) begin
      d.insn_class   = apd_pkg::CLS_MOVZ;
    end
    return d;
  endfunction

  // Mask and match of one encoding family, picked by index.
  function automatic void family_pattern(input int unsigned family,
                                         output logic [31:0] mask,
                                         output logic [31:0] match);
    case (family)
      0: begin mask = apd_pkg::ADRP_MASK;   match = apd_pkg::ADRP_MATCH;  end
      1: begin mask = apd_pkg::ADD_MASK;    match = apd_pkg::ADD_MATCH;   end
      2: begin mask = apd_pkg::LDR_MASK;    match = apd_pkg::LDR32_MATCH; end
      3: begin mask = apd_pkg::LDR_MASK;    match = apd_pkg::LDR64_MATCH; end
      4: begin mask = apd_pkg::BR_IMM_MASK; match = apd_pkg::BL_MATCH;    end
      5: begin mask = apd_pkg::BR_IMM_MASK; match = apd_pkg::B_MATCH;     end
      6: begin mask = apd_pkg::BR_REG_MASK; match = apd_pkg::BLR_MATCH;   end
      7: begin mask = apd_pkg::BR_REG_MASK; match = apd_pkg::BR_MATCH;    end
      8: begin mask = apd_pkg::BR_REG_MASK; match = apd_pkg::RET_MATCH;   end
      9: begin mask = apd_pkg::MOV_MASK;    match = apd_pkg::MOV_MATCH;   end
      default: begin
        mask  = apd_pkg::MOVZ_MASK;
        match = apd_pkg::MOVZ_MATCH;
      end
    endcase
  endfunction

  // Most words are well-formed members of a family with random free bits.
  // Some are near misses with one fixed bit flipped, the rest raw noise.
  function automatic logic [31:0] random_word();
    logic [31:0] mask;
    logic [31:0] match;
    logic [31:0] w;
    int unsigned pick;
    logic [4:0]  flip;
    pick = $urandom_range(15);
    if (pick >= 13) return $urandom;
    family_pattern($urandom_range(10), mask, match);
    w = match | ($urandom & ~mask);
    if (pick >= 11) begin
      do begin
        flip = 5'($urandom_range(31));
      end while (!mask[flip]);
      w[flip] = ~w[flip];
    end
    return w;
  endfunction

  // Program counters lean on the extremes so the page arithmetic wraps often.
  function automatic logic [63:0] random_pc();
    case ($urandom_range(7))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_word(input logic [63:0] pc, input logic [31:0] w);
    apd_pkg::apd_item_t item;
    item.pc               = pc;
    item.instruction_word = w;
    pending_words.push_back(item);
    words_queued++;
  endtask

  function automatic bit take_a_break();
    if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) return 1'b0;
    return $urandom_range(99) < 20;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch on result %0d: %s got %h want %h", results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_decode(input apd_pkg::apd_result_t want);
    if (out_ch.insn_class !== want.insn_class)
      report_mismatch("insn_class", 64'(out_ch.insn_class), 64'(want.insn_class));
    if (out_ch.dest_reg !== want.dest_reg)
      report_mismatch("dest_reg", 64'(out_ch.dest_reg), 64'(want.dest_reg));
    if (out_ch.base_reg !== want.base_reg)
      report_mismatch("base_reg", 64'(out_ch.base_reg), 64'(want.base_reg));
    if (out_ch.source_reg !== want.source_reg)
      report_mismatch("source_reg", 64'(out_ch.source_reg), 64'(want.source_reg));
    if (out_ch.immediate !== want.immediate)
      report_mismatch("immediate", 64'(out_ch.immediate), 64'(want.immediate));
    if (out_ch.access_scale !== want.access_scale)
      report_mismatch("access_scale", 64'(out_ch.access_scale), 64'(want.access_scale));
    if (out_ch.page_target !== want.page_target)
      report_mismatch("page_target", out_ch.page_target, want.page_target);
    if (out_ch.branch_offset !== want.branch_offset)
      report_mismatch("branch_offset", 64'(unsigned'(out_ch.branch_offset)),
                      64'(unsigned'(want.branch_offset)));
  endtask

  // Input driver. A beat moves at an edge where valid and ready are both
  // high; its decode is queued right then. A new beat goes out whenever the
  // current one has moved or none is offered, unless this cycle idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_decodes.push_back(decode_word(in_ch.pc, in_ch.instruction_word));
        words_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() != 0 && !take_a_break()) begin
          next_word                = pending_words.pop_front();
          in_ch.valid             <= 1'b1;
          in_ch.pc                <= next_word.pc;
          in_ch.instruction_word  <= next_word.instruction_word;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each beat taken is held against the oldest decode owed;
  // a beat with nothing owed is itself a failure. Ready drops at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_decodes.size() == 0)
          report_mismatch("beat with no decode owed", 64'(out_ch.insn_class), '0);
        else
          check_decode(expected_decodes.pop_front());
        results_seen++;
      end
      out_ch.ready <= !take_a_break();
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.pc               = '0;
    in_ch.instruction_word = '0;
    out_ch.ready           = 1'b0;
    words_queued           = 0;
    words_accepted         = 0;
    results_seen           = 0;
    mismatch_count         = 0;
    cycle_count            = 0;

    // ADRP: largest forward page count from the top address wraps past zero,
    // the most negative count from zero wraps below it, and minus one page.
    queue_word('1, 32'hF07F_FFFF);
    queue_word('0, 32'h9080_0000);
    queue_word(64'h8000_0000_0000_0FFF, 32'hF0FF_FFE5);
    // ADD immediate: zero, widest unshifted and shifted imm12, and ADDS,
    // which sits one bit away and must not decode.
    queue_word('0, 32'h1100_0000);
    queue_word('1, 32'h913F_FFFF);
    queue_word('1, 32'h917F_FFFF);
    queue_word('1, 32'h3100_0000);
    // Unsigned-offset loads, 32 and 64 bit, at both ends of every field.
    queue_word('0, 32'hB940_0000);
    queue_word('1, 32'hB97F_FFFF);
    queue_word('0, 32'hF940_0000);
    queue_word('1, 32'hF97F_FFFF);
    // BL and B: zero, farthest forward, farthest back, minus one and plus one word.
    queue_word('0, 32'h9400_0000);
    queue_word('1, 32'h95FF_FFFF);
    queue_word('1, 32'h9600_0000);
    queue_word('0, 32'h17FF_FFFF);
    queue_word('0, 32'h1400_0001);
    // Register branches.
    queue_word('1, 32'hD63F_03E0);
    queue_word('0, 32'hD61F_0000);
    queue_word('1, 32'hD65F_03C0);
    // MOV register, both widths, then MOVZ, which is classified only.
    queue_word('1, 32'h2A1F_03FF);
    queue_word('0, 32'hAA01_03E2);
    queue_word('0, 32'h5280_0000);
    queue_word('1, 32'hD2FF_FFFF);
    // Words that match nothing.
    queue_word('1, 32'h0000_0000);
    queue_word('0, 32'hFFFF_FFFF);

    repeat (RANDOM_WORDS) queue_word(random_pc(), random_word());

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every beat has been taken and every decode has come back.
    while (words_accepted < words_queued || expected_decodes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule : aarch64_instruction_predecoder_tb

FILE: aarch64_instruction_predecoder.f
hw/rtl/apd_pkg.sv
hw/rtl/apd_in_if.sv
hw/rtl/apd_out_if.sv
hw/rtl/apd_decode.sv
hw/rtl/aarch64_instruction_predecoder.sv
tb/aarch64_instruction_predecoder_tb.sv
